[hdl/sorted_insert_buffer_assert.svh]
// Assertion macros shared by the sorted insert buffer modules.
`ifndef SORTED_INSERT_BUFFER_ASSERT_SVH
`define SORTED_INSERT_BUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sib_pkg.sv]
// Package with the types, constants and codes of the sorted insert buffer.
package sib_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int PAY_W = 8;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  localparam logic [1:0] STATUS_EMIT  = 2'd0;
  localparam logic [1:0] STATUS_DROP  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef logic [CNT_W-1:0] cnt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       insert;
    logic       pop;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_last;
  } sib_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic count_full;
    logic out_valid;
  } sib_stat_t;

endpackage

[hdl/sib_datapath.sv]
// Datapath: a row of sorted key and payload cells, the entry count and the output register.
`include "sorted_insert_buffer_assert.svh"

module sib_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sib_pkg::sib_cmd_t         cmd,
  output sib_pkg::sib_stat_t        stat,
  input  logic signed [31:0]        in_key,
  input  logic [7:0]                in_payload,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic signed [31:0]        out_key,
  output logic [7:0]                out_payload,
  output logic                      out_last
);
  import sib_pkg::*;

  logic signed [KEY_W-1:0] key_r   [DEPTH];
  logic        [PAY_W-1:0] pay_r   [DEPTH];
  logic signed [KEY_W-1:0] key_nxt [DEPTH];
  logic        [PAY_W-1:0] pay_nxt [DEPTH];
  logic [DEPTH-1:0]        sel;
  cnt_t                    count_r;
  cnt_t                    count_nxt;

  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic [PAY_W-1:0]        out_payload_r;
  logic                    out_last_r;

  // Each cell compares the new key with its own entry. Because the row is
  // sorted, the selected cells form one run from the insert position up to
  // the first free cell; inside that run every cell takes its neighbor's
  // entry, and the head of the run takes the new pair.
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [KEY_W-1:0] shl_key;
      logic        [PAY_W-1:0] shl_pay;
      logic                    prev_sel;

      assign sel[g] = ((cnt_t'(g) < count_r) && (in_key < key_r[g])) ||
                      (cnt_t'(g) == count_r);

      if (g == 0) begin : g_first
        assign prev_sel = 1'b0;
      end else begin : g_rest
        assign prev_sel = sel[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign shl_key = key_r[g];
        assign shl_pay = pay_r[g];
      end else begin : g_inner
        assign shl_key = key_r[g+1];
        assign shl_pay = pay_r[g+1];
      end

      always_comb begin
        key_nxt[g] = key_r[g];
        pay_nxt[g] = pay_r[g];
        if (cmd.insert && sel[g]) begin
          if (prev_sel) begin
            if (g == 0) begin
              key_nxt[g] = in_key;
              pay_nxt[g] = in_payload;
            end else begin
              key_nxt[g] = key_r[(g == 0) ? 0 : g-1];
              pay_nxt[g] = pay_r[(g == 0) ? 0 : g-1];
            end
          end else begin
            key_nxt[g] = in_key;
            pay_nxt[g] = in_payload;
          end
        end else if (cmd.pop) begin
          key_nxt[g] = shl_key;
          pay_nxt[g] = shl_pay;
        end
      end

      always_ff @(posedge clk) begin
        key_r[g] <= key_nxt[g];
        pay_r[g] <= pay_nxt[g];
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
      if (cmd.out_status == STATUS_EMIT) begin
        out_key_r     <= key_r[0];
        out_payload_r <= pay_r[0];
      end else begin
        out_key_r     <= '0;
        out_payload_r <= '0;
      end
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.count_one  = (count_r == cnt_t'(1));
  assign stat.count_full = (count_r == cnt_t'(DEPTH));
  assign stat.out_valid  = out_valid_r;

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key     = out_key_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;

  `SIB_ASSERT_NOW(a_count_max, 1'b1, count_r <= cnt_t'(DEPTH), "entry count above depth")
  `SIB_ASSERT_NEXT(a_insert_count, cmd.insert, count_r == $past(count_r) + cnt_t'(1), "insert did not grow count")
  `SIB_ASSERT_NOW(a_status_zero, out_valid_r && (out_status_r != STATUS_EMIT), (out_key_r == '0) && (out_payload_r == '0), "non-entry request carries data")

endmodule

[hdl/sib_controller.sv]
// Controller: accepts requests, sequences drains and issues datapath commands.
`include "sorted_insert_buffer_assert.svh"

module sib_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_stall,
  input  logic                out_stall,
  input  sib_pkg::sib_stat_t  stat,
  output sib_pkg::sib_cmd_t   cmd
);
  import sib_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_free;
  logic accept;

  // The output register can take a new request when empty or being emptied.
  assign out_free = !stat.out_valid || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd.insert     = 1'b0;
    cmd.pop        = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.out_status = STATUS_EMIT;
    cmd.out_last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_INSERT) begin
            if (stat.count_full) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = STATUS_DROP;
              cmd.out_last   = 1'b1;
            end else begin
              cmd.insert = 1'b1;
            end
          end else if (stat.count_zero) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = STATUS_EMPTY;
            cmd.out_last   = 1'b1;
          end else begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          cmd.pop        = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = STATUS_EMIT;
          cmd.out_last   = stat.count_one;
          if (stat.count_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SIB_ASSERT_NOW(a_drain_nonempty, state_r == S_DRAIN, !stat.count_zero, "draining an empty buffer")
  `SIB_ASSERT_NOW(a_drain_stalls, state_r == S_DRAIN, in_stall, "request taken during drain")
  `SIB_ASSERT_NEXT(a_drain_ends, (state_r == S_DRAIN) && cmd.pop && stat.count_one, state_r == S_IDLE, "drain did not end after last entry")

endmodule

[hdl/sorted_insert_buffer.sv]
// Sorted insert buffer: holds up to DEPTH (16) key and payload pairs in
// ascending signed key order in a row of compare-and-shift cells. An insert
// request lands before the first stored key that is strictly greater, so equal
// keys keep arrival order; an insert into a full buffer gives one result with
// the dropped status. A drain request streams out every stored entry, one per
// cycle from the head cell unless the output stalls, with last on the final
// one, and leaves the buffer empty; draining an empty buffer gives one result
// with the empty status. A request is taken whenever no drain is in progress
// and the single output register is free or being emptied, so inserts run at
// one per cycle unless the output stalls. No clearing pass after reset.
module sorted_insert_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_key,
  input  logic [7:0]         in_payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_key,
  output logic [7:0]         out_payload,
  output logic               out_last
);
  import sib_pkg::*;

  sib_cmd_t  cmd;
  sib_stat_t stat;

  sib_controller u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  sib_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_key      (in_key),
    .in_payload  (in_payload),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_key     (out_key),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

endmodule
